// ===== rtl/sscd_pkg.sv =====
package sscd_pkg;

   // Default buffer sizes
   localparam int INFO_BLOCK_BYTES_DEF   = 32;
   localparam int STATUS_BLOCK_BYTES_DEF = 14;
   localparam int FRAME_BUFFER_BYTES_DEF = 16;

   // Transmit buffer index is 4 bits wide
   localparam int STORE_INDEX_SPAN = 16;

   // Fixed reply bytes
   localparam logic [7:0] REPLY_NONE = 8'h00;
   localparam logic [7:0] REPLY_OK   = 8'h80;
   localparam logic [7:0] REPLY_MORE = 8'hA0;
   localparam logic [7:0] REPLY_ERR  = 8'hFF;

   // Key byte that unlocks the bootloader command
   localparam logic [7:0] BOOT_KEY = 8'h17;

   // Event kinds
   localparam logic OPER_SELECT = 1'b0;
   localparam logic OPER_BYTE   = 1'b1;

   // Opcodes
   localparam logic [3:0] OP_RST    = 4'd1;
   localparam logic [3:0] OP_INFO   = 4'd2;
   localparam logic [3:0] OP_STBLK  = 4'd3;
   localparam logic [3:0] OP_POWER  = 4'd4;
   localparam logic [3:0] OP_STATUS = 4'd6;
   localparam logic [3:0] OP_STORE  = 4'd7;
   localparam logic [3:0] OP_SEND   = 4'd8;
   localparam logic [3:0] OP_FETCH  = 4'd9;
   localparam logic [3:0] OP_ACK    = 4'd10;
   localparam logic [3:0] OP_LIMIT  = 4'd11;
   localparam logic [3:0] OP_BOOT   = 4'd12;

   // Reset sub-commands
   localparam logic [7:0] RST_BUS = 8'd1;
   localparam logic [7:0] RST_SYS = 8'd2;

   // Read sources
   localparam logic [2:0] SRC_NONE   = 3'd0;
   localparam logic [2:0] SRC_INFO   = 3'd1;
   localparam logic [2:0] SRC_STBLK  = 3'd2;
   localparam logic [2:0] SRC_STATUS = 3'd3;
   localparam logic [2:0] SRC_RXBUF  = 3'd4;

   // Side actions
   localparam logic [3:0] ACT_NONE       = 4'd0;
   localparam logic [3:0] ACT_BUS_RESET  = 4'd1;
   localparam logic [3:0] ACT_SYS_RESET  = 4'd2;
   localparam logic [3:0] ACT_POWER_OFF  = 4'd3;
   localparam logic [3:0] ACT_POWER_ON   = 4'd4;
   localparam logic [3:0] ACT_CLR_COMMIT = 4'd5;
   localparam logic [3:0] ACT_COMMIT     = 4'd6;
   localparam logic [3:0] ACT_ACK_RX     = 4'd7;
   localparam logic [3:0] ACT_LIMIT      = 4'd8;
   localparam logic [3:0] ACT_BOOT       = 4'd9;
   localparam logic [3:0] ACT_STORE      = 4'd10;

   // Decoder state carried between beats
   typedef struct packed {
      logic        awaiting_opcode;
      logic [3:0]  command_code;
      logic [7:0]  byte_offset;
      logic [15:0] limit_value;
   } state_type;

   // One result beat
   typedef struct packed {
      logic        reply_valid;
      logic [7:0]  reply_code;
      logic [2:0]  read_source;
      logic [7:0]  read_index;
      logic [3:0]  action;
      logic [3:0]  store_index;
      logic [7:0]  store_data;
      logic [15:0] current_limit;
   } result_type;

endpackage

// ===== rtl/sscd_decode.sv =====
module sscd_decode #(
   parameter int INFO_BLOCK_BYTES   = sscd_pkg::INFO_BLOCK_BYTES_DEF,
   parameter int STATUS_BLOCK_BYTES = sscd_pkg::STATUS_BLOCK_BYTES_DEF,
   parameter int FRAME_BUFFER_BYTES = sscd_pkg::FRAME_BUFFER_BYTES_DEF
) (
   input  logic                  operation,
   input  logic [7:0]            rx_byte,
   input  logic                  tx_queue_two_or_more,
   input  sscd_pkg::state_type   state_cur,
   output sscd_pkg::state_type   state_nxt,
   output sscd_pkg::result_type  result
);

   localparam int StoreLimit = (FRAME_BUFFER_BYTES < sscd_pkg::STORE_INDEX_SPAN) ?
                               FRAME_BUFFER_BYTES : sscd_pkg::STORE_INDEX_SPAN;
   localparam logic [8:0] InfoLim   = 9'(INFO_BLOCK_BYTES);
   localparam logic [8:0] StblkLim  = 9'(STATUS_BLOCK_BYTES);
   localparam logic [8:0] FrameLim  = 9'(FRAME_BUFFER_BYTES);
   localparam logic [8:0] StoreLim  = 9'(StoreLimit);

   logic       start;
   logic [7:0] offset;
   logic [3:0] opcode;
   logic [8:0] off_ext;
   logic [7:0] off_dec;

   // Opcode capture or offset advance
   always_comb begin
      if (state_cur.awaiting_opcode) begin
         start  = 1'b1;
         opcode = rx_byte[3:0];
         offset = 8'd0;
      end else begin
         start  = 1'b0;
         opcode = state_cur.command_code;
         offset = (state_cur.byte_offset == 8'hFF) ? 8'hFF : state_cur.byte_offset + 8'd1;
      end
      off_ext = {1'b0, offset};
      off_dec = offset - 8'd1;
   end

   // Reply rules per opcode
   always_comb begin
      state_nxt = state_cur;
      result    = '0;
      if (operation == sscd_pkg::OPER_SELECT) begin
         state_nxt.awaiting_opcode = 1'b1;
      end else begin
         state_nxt.awaiting_opcode = 1'b0;
         state_nxt.command_code    = opcode;
         state_nxt.byte_offset     = offset;
         result.reply_valid        = 1'b1;
         result.reply_code         = sscd_pkg::REPLY_ERR;
         case (opcode)
            sscd_pkg::OP_RST: begin
               if (start) begin
                  result.reply_code = sscd_pkg::REPLY_MORE;
               end else if (offset == 8'd1 && rx_byte == sscd_pkg::RST_BUS) begin
                  result.reply_code = sscd_pkg::REPLY_OK;
                  result.action     = sscd_pkg::ACT_BUS_RESET;
               end else if (offset == 8'd1 && rx_byte == sscd_pkg::RST_SYS) begin
                  result.reply_code = sscd_pkg::REPLY_OK;
                  result.action     = sscd_pkg::ACT_SYS_RESET;
               end
            end
            sscd_pkg::OP_INFO: begin
               if (off_ext < InfoLim) begin
                  result.reply_code  = sscd_pkg::REPLY_NONE;
                  result.read_source = sscd_pkg::SRC_INFO;
                  result.read_index  = offset;
               end
            end
            sscd_pkg::OP_STBLK: begin
               if (off_ext < StblkLim) begin
                  result.reply_code  = sscd_pkg::REPLY_NONE;
                  result.read_source = sscd_pkg::SRC_STBLK;
                  result.read_index  = offset;
               end
            end
            sscd_pkg::OP_POWER: begin
               if (start) begin
                  result.reply_code = sscd_pkg::REPLY_MORE;
               end else if (offset == 8'd1) begin
                  result.reply_code = sscd_pkg::REPLY_OK;
                  result.action     = (rx_byte == 8'd0) ? sscd_pkg::ACT_POWER_OFF :
                                                          sscd_pkg::ACT_POWER_ON;
               end
            end
            sscd_pkg::OP_STATUS: begin
               result.reply_code  = sscd_pkg::REPLY_NONE;
               result.read_source = sscd_pkg::SRC_STATUS;
            end
            sscd_pkg::OP_STORE: begin
               if (start) begin
                  result.reply_code = sscd_pkg::REPLY_MORE;
               end else if (off_ext < StoreLim) begin
                  // store beat carries no reply byte
                  result.reply_valid = 1'b0;
                  result.reply_code  = sscd_pkg::REPLY_NONE;
                  result.action      = sscd_pkg::ACT_STORE;
                  result.store_index = off_dec[3:0];
                  result.store_data  = rx_byte;
               end
            end
            sscd_pkg::OP_SEND: begin
               if (start) begin
                  result.reply_code = sscd_pkg::REPLY_OK;
                  result.action     = tx_queue_two_or_more ? sscd_pkg::ACT_CLR_COMMIT :
                                                             sscd_pkg::ACT_COMMIT;
               end
            end
            sscd_pkg::OP_FETCH: begin
               if (off_ext < FrameLim) begin
                  result.reply_code  = sscd_pkg::REPLY_NONE;
                  result.read_source = sscd_pkg::SRC_RXBUF;
                  result.read_index  = offset;
               end
            end
            sscd_pkg::OP_ACK: begin
               if (start) begin
                  result.reply_code = sscd_pkg::REPLY_OK;
                  result.action     = sscd_pkg::ACT_ACK_RX;
               end
            end
            sscd_pkg::OP_LIMIT: begin
               if (start) begin
                  result.reply_code = sscd_pkg::REPLY_MORE;
               end else if (offset == 8'd1) begin
                  result.reply_code     = sscd_pkg::REPLY_MORE;
                  state_nxt.limit_value = {rx_byte, 8'd0};
               end else if (offset == 8'd2) begin
                  result.reply_code     = sscd_pkg::REPLY_OK;
                  result.action         = sscd_pkg::ACT_LIMIT;
                  state_nxt.limit_value = {state_cur.limit_value[15:8],
                                           state_cur.limit_value[7:0] | rx_byte};
               end
            end
            sscd_pkg::OP_BOOT: begin
               if (start) begin
                  result.reply_code = sscd_pkg::REPLY_MORE;
               end else if (offset == 8'd1 && rx_byte == sscd_pkg::BOOT_KEY) begin
                  result.reply_code = sscd_pkg::REPLY_OK;
                  result.action     = sscd_pkg::ACT_BOOT;
               end
            end
            default: begin
               result.reply_code = sscd_pkg::REPLY_ERR;
            end
         endcase
      end
      result.current_limit = state_nxt.limit_value;
   end

endmodule

// ===== rtl/spi_slave_command_decoder.sv =====
// SPI slave command decoder. Each input beat is a select event or a received
// byte and yields exactly one result beat: a fixed reply code, a read request
// into the info block, status block, status byte or receive buffer, a side
// action code and the current 16-bit limit. One beat is taken per clock while
// the result register is free or being drained; an accepted beat is decoded
// from the input register and written to the result register, which drives
// the result port. The command state is updated at the same edge, so the
// next beat may follow directly. Reset and bootloader effects are only
// reported as action codes.
module spi_slave_command_decoder #(
   parameter int INFO_BLOCK_BYTES   = sscd_pkg::INFO_BLOCK_BYTES_DEF,
   parameter int STATUS_BLOCK_BYTES = sscd_pkg::STATUS_BLOCK_BYTES_DEF,
   parameter int FRAME_BUFFER_BYTES = sscd_pkg::FRAME_BUFFER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_tx_queue_two_or_more,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_reply_valid,
   output logic [7:0]  rsp_reply_code,
   output logic [2:0]  rsp_read_source,
   output logic [7:0]  rsp_read_index,
   output logic [3:0]  rsp_action,
   output logic [3:0]  rsp_store_index,
   output logic [7:0]  rsp_store_data,
   output logic [15:0] rsp_current_limit
);

   logic                 in_valid_ff, in_valid_in;
   logic                 in_op_ff;
   logic [7:0]           in_byte_ff;
   logic                 in_txq_ff;
   sscd_pkg::state_type  state_ff, state_in, state_dec;
   sscd_pkg::result_type rsp_ff, result_dec;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 advance;
   logic                 accept;

   // Handshake: the result register frees up when empty or being drained
   assign advance   = ~rsp_valid_ff | rsp_ready;
   assign req_ready = ~in_valid_ff | advance;
   assign accept    = req_valid & req_ready;

   assign in_valid_in  = accept | (in_valid_ff & ~advance);
   assign rsp_valid_in = (in_valid_ff & advance) | (rsp_valid_ff & ~rsp_ready);
   assign state_in     = (in_valid_ff & advance) ? state_dec : state_ff;

   sscd_decode #(
      .INFO_BLOCK_BYTES   (INFO_BLOCK_BYTES),
      .STATUS_BLOCK_BYTES (STATUS_BLOCK_BYTES),
      .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
   ) u_decode (
      .operation            (in_op_ff),
      .rx_byte              (in_byte_ff),
      .tx_queue_two_or_more (in_txq_ff),
      .state_cur            (state_ff),
      .state_nxt            (state_dec),
      .result               (result_dec)
   );

   // Control and command state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff   <= req_operation;
         in_byte_ff <= req_rx_byte;
         in_txq_ff  <= req_tx_queue_two_or_more;
      end
      if (in_valid_ff & advance) begin
         rsp_ff <= result_dec;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_reply_valid   = rsp_ff.reply_valid;
   assign rsp_reply_code    = rsp_ff.reply_code;
   assign rsp_read_source   = rsp_ff.read_source;
   assign rsp_read_index    = rsp_ff.read_index;
   assign rsp_action        = rsp_ff.action;
   assign rsp_store_index   = rsp_ff.store_index;
   assign rsp_store_data    = rsp_ff.store_data;
   assign rsp_current_limit = rsp_ff.current_limit;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int STORE_LIMIT  =
      (sscd_pkg::FRAME_BUFFER_BYTES_DEF < sscd_pkg::STORE_INDEX_SPAN) ?
      sscd_pkg::FRAME_BUFFER_BYTES_DEF : sscd_pkg::STORE_INDEX_SPAN;
   localparam int RANDOM_BEATS = 950;
   localparam int HOLD_CYCLES  = 80;

   // One SPI event as seen on the input channel
   typedef struct {
      logic       operation;
      logic [7:0] rx_byte;
      logic       txq_two;
   } spi_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_operation = 1'b0;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_tx_queue_two_or_more = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_reply_valid;
   logic [7:0]  rsp_reply_code;
   logic [2:0]  rsp_read_source;
   logic [7:0]  rsp_read_index;
   logic [3:0]  rsp_action;
   logic [3:0]  rsp_store_index;
   logic [7:0]  rsp_store_data;
   logic [15:0] rsp_current_limit;

   spi_event_type        spi_events[$];
   sscd_pkg::result_type predicted_replies[$];
   sscd_pkg::state_type  decoder_state;

   spi_event_type next_event;
   int         queued_beats = 0;
   int         accepted_beats = 0;
   int         cycle_count = 0;
   int         fail_count = 0;
   int         req_gap = 0;
   int         rsp_stall = 0;
   bit         req_taken = 1'b0;
   bit         rsp_hold = 1'b0;
   bit         idle_allowed = 1'b0;

   spi_slave_command_decoder dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_operation            (req_operation),
      .req_rx_byte              (req_rx_byte),
      .req_tx_queue_two_or_more (req_tx_queue_two_or_more),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_reply_valid          (rsp_reply_valid),
      .rsp_reply_code           (rsp_reply_code),
      .rsp_read_source          (rsp_read_source),
      .rsp_read_index           (rsp_read_index),
      .rsp_action               (rsp_action),
      .rsp_store_index          (rsp_store_index),
      .rsp_store_data           (rsp_store_data),
      .rsp_current_limit        (rsp_current_limit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decoder prediction: updates the command state and returns the reply
   function automatic sscd_pkg::result_type decode_spi_event(spi_event_type ev);
      sscd_pkg::result_type r;
      logic       start;
      logic [7:0] p;
      logic [7:0] o;
      r = '0;
      p = ev.rx_byte;
      if (ev.operation == sscd_pkg::OPER_SELECT) begin
         decoder_state.awaiting_opcode = 1'b1;
         r.current_limit = decoder_state.limit_value;
         return r;
      end
      if (decoder_state.awaiting_opcode) begin
         decoder_state.command_code = p[3:0];
         decoder_state.byte_offset = 8'd0;
         decoder_state.awaiting_opcode = 1'b0;
         start = 1'b1;
      end else begin
         if (decoder_state.byte_offset != 8'hFF)
            decoder_state.byte_offset = decoder_state.byte_offset + 8'd1;
         start = 1'b0;
      end
      o = decoder_state.byte_offset;
      r.reply_valid = 1'b1;
      r.reply_code = sscd_pkg::REPLY_ERR;
      case (decoder_state.command_code)
         sscd_pkg::OP_RST: begin
            if (start)
               r.reply_code = sscd_pkg::REPLY_MORE;
            else if (o == 8'd1 && p == sscd_pkg::RST_BUS) begin
               r.reply_code = sscd_pkg::REPLY_OK;
               r.action = sscd_pkg::ACT_BUS_RESET;
            end else if (o == 8'd1 && p == sscd_pkg::RST_SYS) begin
               r.reply_code = sscd_pkg::REPLY_OK;
               r.action = sscd_pkg::ACT_SYS_RESET;
            end
         end
         sscd_pkg::OP_INFO: begin
            if (o < sscd_pkg::INFO_BLOCK_BYTES_DEF) begin
               r.reply_code = sscd_pkg::REPLY_NONE;
               r.read_source = sscd_pkg::SRC_INFO;
               r.read_index = o;
            end
         end
         sscd_pkg::OP_STBLK: begin
            if (o < sscd_pkg::STATUS_BLOCK_BYTES_DEF) begin
               r.reply_code = sscd_pkg::REPLY_NONE;
               r.read_source = sscd_pkg::SRC_STBLK;
               r.read_index = o;
            end
         end
         sscd_pkg::OP_POWER: begin
            if (start)
               r.reply_code = sscd_pkg::REPLY_MORE;
            else if (o == 8'd1) begin
               r.reply_code = sscd_pkg::REPLY_OK;
               r.action = (p == 8'd0) ? sscd_pkg::ACT_POWER_OFF : sscd_pkg::ACT_POWER_ON;
            end
         end
         sscd_pkg::OP_STATUS: begin
            r.reply_code = sscd_pkg::REPLY_NONE;
            r.read_source = sscd_pkg::SRC_STATUS;
         end
         sscd_pkg::OP_STORE: begin
            if (start)
               r.reply_code = sscd_pkg::REPLY_MORE;
            else if (o < STORE_LIMIT) begin
               // parameter bytes go to the transmit buffer without a reply
               r.reply_valid = 1'b0;
               r.reply_code = sscd_pkg::REPLY_NONE;
               r.action = sscd_pkg::ACT_STORE;
               r.store_index = 4'(o - 8'd1);
               r.store_data = p;
            end
         end
         sscd_pkg::OP_SEND: begin
            if (start) begin
               r.reply_code = sscd_pkg::REPLY_OK;
               r.action = ev.txq_two ? sscd_pkg::ACT_CLR_COMMIT : sscd_pkg::ACT_COMMIT;
            end
         end
         sscd_pkg::OP_FETCH: begin
            if (o < sscd_pkg::FRAME_BUFFER_BYTES_DEF) begin
               r.reply_code = sscd_pkg::REPLY_NONE;
               r.read_source = sscd_pkg::SRC_RXBUF;
               r.read_index = o;
            end
         end
         sscd_pkg::OP_ACK: begin
            if (start) begin
               r.reply_code = sscd_pkg::REPLY_OK;
               r.action = sscd_pkg::ACT_ACK_RX;
            end
         end
         sscd_pkg::OP_LIMIT: begin
            if (start)
               r.reply_code = sscd_pkg::REPLY_MORE;
            else if (o == 8'd1) begin
               r.reply_code = sscd_pkg::REPLY_MORE;
               decoder_state.limit_value = {p, 8'h00};
            end else if (o == 8'd2) begin
               r.reply_code = sscd_pkg::REPLY_OK;
               decoder_state.limit_value = decoder_state.limit_value | {8'h00, p};
               r.action = sscd_pkg::ACT_LIMIT;
            end
         end
         sscd_pkg::OP_BOOT: begin
            if (start)
               r.reply_code = sscd_pkg::REPLY_MORE;
            else if (o == 8'd1 && p == sscd_pkg::BOOT_KEY) begin
               r.reply_code = sscd_pkg::REPLY_OK;
               r.action = sscd_pkg::ACT_BOOT;
            end
         end
         default: r.reply_code = sscd_pkg::REPLY_ERR;
      endcase
      r.current_limit = decoder_state.limit_value;
      return r;
   endfunction

   task automatic queue_event(logic op, logic [7:0] rx, logic txq);
      spi_event_type ev;
      ev.operation = op;
      ev.rx_byte = rx;
      ev.txq_two = txq;
      spi_events.push_back(ev);
      queued_beats++;
   endtask

   task automatic queue_select();
      queue_event(sscd_pkg::OPER_SELECT, 8'($urandom), 1'($urandom));
   endtask

   task automatic queue_byte(logic [7:0] b);
      queue_event(sscd_pkg::OPER_BYTE, b, 1'($urandom));
   endtask

   // Parameter byte biased toward the values that the opcode acts on
   function automatic logic [7:0] pick_param(logic [3:0] op);
      int sel;
      sel = $urandom_range(0, 3);
      case (op)
         sscd_pkg::OP_RST:
            return (sel == 0) ? 8'($urandom) :
                   ((sel == 1) ? sscd_pkg::RST_BUS : sscd_pkg::RST_SYS);
         sscd_pkg::OP_POWER: return (sel < 2) ? 8'd0 : 8'($urandom);
         sscd_pkg::OP_BOOT:  return (sel < 3) ? sscd_pkg::BOOT_KEY : 8'($urandom);
         default:            return 8'($urandom);
      endcase
   endfunction

   // Select, opcode byte with random upper nibble, then parameters
   task automatic queue_command(logic [3:0] op, int n_params);
      queue_select();
      queue_byte({4'($urandom), op});
      repeat (n_params) queue_byte(pick_param(op));
   endtask

   function automatic int pick_length(logic [3:0] op);
      case (op)
         sscd_pkg::OP_INFO:  return $urandom_range(0, sscd_pkg::INFO_BLOCK_BYTES_DEF + 2);
         sscd_pkg::OP_STBLK: return $urandom_range(0, sscd_pkg::STATUS_BLOCK_BYTES_DEF + 2);
         sscd_pkg::OP_FETCH: return $urandom_range(0, sscd_pkg::FRAME_BUFFER_BYTES_DEF + 2);
         sscd_pkg::OP_STORE: return $urandom_range(0, STORE_LIMIT + 2);
         default:            return $urandom_range(0, 3);
      endcase
   endfunction

   task check_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
         fail_count++;
      end
   endtask

   // Input side: present the next event once the previous beat has gone
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (spi_events.size() > 0) begin
            next_event = spi_events.pop_front();
            req_valid <= 1'b1;
            req_operation <= next_event.operation;
            req_rx_byte <= next_event.rx_byte;
            req_tx_queue_two_or_more <= next_event.txq_two;
            if (idle_allowed && $urandom_range(0, 7) == 0)
               req_gap = $urandom_range(1, 6);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: random stall bursts, plus the long hold-off
   always @(negedge clock) begin
      if (rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else if (idle_allowed && $urandom_range(0, 9) == 0) begin
         rsp_stall = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Hold off the result side long enough that the block fills and stalls
   initial begin
      wait (accepted_beats >= 300);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // Monitor: predict on accepted inputs, check accepted results
   always @(posedge clock) begin
      sscd_pkg::result_type got;
      sscd_pkg::result_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_allowed = (spi_events.size() >= 100) && ((accepted_beats % 128) < 96);
         if (!reset && rsp_valid && rsp_ready) begin
            got.reply_valid = rsp_reply_valid;
            got.reply_code = rsp_reply_code;
            got.read_source = rsp_read_source;
            got.read_index = rsp_read_index;
            got.action = rsp_action;
            got.store_index = rsp_store_index;
            got.store_data = rsp_store_data;
            got.current_limit = rsp_current_limit;
            if (predicted_replies.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, got %0h", $time, got);
               fail_count++;
            end else begin
               want = predicted_replies.pop_front();
               check_field("reply_valid", want.reply_valid, got.reply_valid);
               check_field("reply_code", want.reply_code, got.reply_code);
               check_field("read_source", want.read_source, got.read_source);
               check_field("read_index", want.read_index, got.read_index);
               check_field("action", want.action, got.action);
               check_field("store_index", want.store_index, got.store_index);
               check_field("store_data", want.store_data, got.store_data);
               check_field("current_limit", want.current_limit, got.current_limit);
            end
         end
         req_taken = !reset && req_valid && req_ready;
         if (req_taken) begin
            next_event.operation = req_operation;
            next_event.rx_byte = req_rx_byte;
            next_event.txq_two = req_tx_queue_two_or_more;
            predicted_replies.push_back(decode_spi_event(next_event));
            accepted_beats++;
         end
      end
   end

   initial begin
      logic [3:0] op;
      int         pick;
      int         random_start;
      logic [3:0] bounded_ops[4];
      decoder_state = '0;
      bounded_ops = '{sscd_pkg::OP_INFO, sscd_pkg::OP_STBLK, sscd_pkg::OP_STORE,
                      sscd_pkg::OP_FETCH};

      // Directed: byte before any select, reset, limit, boot, power-off, send and ack actions, field extremes
      queue_event(sscd_pkg::OPER_BYTE, 8'h00, 1'b0);
      queue_event(sscd_pkg::OPER_SELECT, 8'hFF, 1'b1);
      queue_event(sscd_pkg::OPER_BYTE, {4'hF, sscd_pkg::OP_RST}, 1'b1);
      queue_event(sscd_pkg::OPER_BYTE, sscd_pkg::RST_BUS, 1'b0);
      queue_event(sscd_pkg::OPER_SELECT, 8'h00, 1'b0);
      queue_event(sscd_pkg::OPER_BYTE, {4'h0, sscd_pkg::OP_RST}, 1'b0);
      queue_event(sscd_pkg::OPER_BYTE, sscd_pkg::RST_SYS, 1'b0);
      queue_event(sscd_pkg::OPER_SELECT, 8'h00, 1'b0);
      queue_event(sscd_pkg::OPER_BYTE, {4'h0, sscd_pkg::OP_LIMIT}, 1'b0);
      queue_event(sscd_pkg::OPER_BYTE, 8'hFF, 1'b1);
      queue_event(sscd_pkg::OPER_BYTE, 8'hFF, 1'b1);
      queue_event(sscd_pkg::OPER_SELECT, 8'h5A, 1'b0);
      queue_event(sscd_pkg::OPER_BYTE, {4'h0, sscd_pkg::OP_BOOT}, 1'b0);
      queue_event(sscd_pkg::OPER_BYTE, sscd_pkg::BOOT_KEY, 1'b0);
      queue_event(sscd_pkg::OPER_SELECT, 8'h00, 1'b0);
      queue_event(sscd_pkg::OPER_BYTE, {4'h0, sscd_pkg::OP_POWER}, 1'b0);
      queue_event(sscd_pkg::OPER_BYTE, 8'h00, 1'b0);
      queue_event(sscd_pkg::OPER_SELECT, 8'h00, 1'b0);
      queue_event(sscd_pkg::OPER_BYTE, {4'h0, sscd_pkg::OP_SEND}, 1'b1);
      queue_event(sscd_pkg::OPER_SELECT, 8'h00, 1'b0);
      queue_event(sscd_pkg::OPER_BYTE, {4'h1, sscd_pkg::OP_SEND}, 1'b0);
      queue_event(sscd_pkg::OPER_SELECT, 8'h00, 1'b0);
      queue_event(sscd_pkg::OPER_BYTE, {4'h0, sscd_pkg::OP_ACK}, 1'b0);
      queue_event(sscd_pkg::OPER_SELECT, 8'h00, 1'b0);
      queue_event(sscd_pkg::OPER_BYTE, {4'h0, sscd_pkg::OP_STATUS}, 1'b0);
      queue_event(sscd_pkg::OPER_BYTE, 8'h37, 1'b1);

      // Random: one long command to saturate the offset, then mixed traffic
      random_start = queued_beats;
      queue_command(bounded_ops[$urandom_range(0, 3)], 260);
      while (queued_beats - random_start < RANDOM_BEATS) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            op = 4'($urandom);
            queue_command(op, pick_length(op));
         end else if (pick < 93) begin
            queue_byte(8'($urandom));
         end else begin
            queue_select();
         end
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: all events sent and every predicted reply seen
      while (spi_events.size() > 0 || req_valid || predicted_replies.size() > 0)
         @(negedge clock);
      repeat (6) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sscd_pkg.sv
rtl/sscd_decode.sv
rtl/spi_slave_command_decoder.sv
sim/tb_top.sv
